/* hw/rtl/bdtd_pkg.sv */
// bdtd_pkg: shared types and constants of the baseline deviation threshold detector
// used by every module under hw/rtl; depends on nothing else
`timescale 1ns / 1ps

package bdtd_pkg;

  // field widths
  localparam int unsigned CH_W   = 4;
  localparam int unsigned VAL_W  = 11;
  localparam int unsigned THR_W  = 8;
  localparam int unsigned DEV_W  = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned DIFF_W = 12;
  localparam int unsigned MAX_CH = 16;

  // magnitude of a calibration sum, at most 15 samples of 1024
  localparam int unsigned ABS_W = 15;

  // exact divide by constant: multiply by ceil(2^DIV_SHIFT / n) and shift
  localparam int unsigned DIV_SHIFT = ABS_W + CNT_W;
  localparam int unsigned MULT_W    = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = ABS_W + MULT_W;

  // saturation limit of deviation and thresholds
  localparam logic [THR_W-1:0] DEV_MAX = 8'hFF;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // request codes, same encoding as the kind field
  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_CAL     = 2'd1,
    OP_SET_ONE = 2'd2,
    OP_SET_ALL = 2'd3
  } op_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t                     op;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;
    logic [THR_W-1:0]        thr;
  } qentry_t;

endpackage

/* hw/rtl/baseline_deviation_threshold_detector.sv */
// Multi-channel baseline deviation detector. One request is taken per clock
// while full is low; a measure request passes through the request queue and
// then into the result register, when that register is free or popped in
// the same cycle.
// A calibration request that completes a channel's baseline holds the back
// end while the sum is divided by the sample count in a multiply stage; the
// four-entry request queue absorbs this, so the sustained rate is one request
// per cycle apart from the baseline divides and waits on the result register.
// Requests other than set-all for channels at or above CHANNELS are dropped without a result.
// top level; depends on bdtd_pkg, bdtd_front, bdtd_queue and bdtd_back
`timescale 1ns / 1ps

module baseline_deviation_threshold_detector #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned CAL_SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         kind,
  input  logic [bdtd_pkg::CH_W-1:0]          channel,
  input  logic signed [bdtd_pkg::VAL_W-1:0]  value,
  output logic                               empty,
  input  logic                               pop,
  output logic [bdtd_pkg::CH_W-1:0]          out_channel,
  output logic [bdtd_pkg::DEV_W-1:0]         deviation,
  output logic                               over_threshold,
  output logic [bdtd_pkg::MAX_CH-1:0]        frame_mask,
  output logic                               mask_valid
);

  logic              wr_en;
  bdtd_pkg::qentry_t wr_entry;
  logic              q_valid;
  logic              q_pop;
  bdtd_pkg::qentry_t q_entry;

  // request classification
  bdtd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .kind     (kind),
    .channel  (channel),
    .value    (value),
    .push     (push),
    .full     (full),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // decoupling queue
  bdtd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .full     (full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_entry (q_entry)
  );

  // execution and result register
  bdtd_back #(
    .CHANNELS    (CHANNELS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_channel    (out_channel),
    .deviation      (deviation),
    .over_threshold (over_threshold),
    .frame_mask     (frame_mask),
    .mask_valid     (mask_valid)
  );

endmodule

/* hw/rtl/bdtd_front.sv */
// bdtd_front: accepts input requests, drops those for absent channels (set-all excepted) and
// saturates threshold values; depends on bdtd_pkg
`timescale 1ns / 1ps

module bdtd_front #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic [1:0]                         kind,
  input  logic [bdtd_pkg::CH_W-1:0]          channel,
  input  logic signed [bdtd_pkg::VAL_W-1:0]  value,
  input  logic                               push,
  input  logic                               full,
  output logic                               wr_en,
  output bdtd_pkg::qentry_t                  wr_entry
);

  logic                           ch_present;
  logic [bdtd_pkg::THR_W-1:0]     thr_sat;
  bdtd_pkg::op_t                  op;

  // decode the request kind
  assign op = bdtd_pkg::op_t'(kind);

  // channel range check, widened so that the channel count itself fits
  assign ch_present = ({1'b0, channel} < (bdtd_pkg::CH_W + 1)'(CHANNELS));

  // threshold saturation to 0..255
  always_comb begin
    if (value[bdtd_pkg::VAL_W-1]) begin
      thr_sat = '0;
    end else if (|value[bdtd_pkg::VAL_W-2:bdtd_pkg::THR_W]) begin
      thr_sat = bdtd_pkg::DEV_MAX;
    end else begin
      thr_sat = value[bdtd_pkg::THR_W-1:0];
    end
  end

  // set-all applies whatever the channel, everything else needs a present channel
  assign wr_en = push && !full && ((op == bdtd_pkg::OP_SET_ALL) || ch_present);

  always_comb begin
    wr_entry.op      = op;
    wr_entry.channel = channel;
    wr_entry.value   = value;
    wr_entry.thr     = thr_sat;
  end

endmodule

/* hw/rtl/bdtd_queue.sv */
// bdtd_queue: short request queue between the front and the back part
// depends on bdtd_pkg
`timescale 1ns / 1ps

module bdtd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  bdtd_pkg::qentry_t wr_entry,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_en,
  output bdtd_pkg::qentry_t rd_entry
);

  bdtd_pkg::qentry_t               entries [bdtd_pkg::QUEUE_DEPTH];
  logic [bdtd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bdtd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bdtd_pkg::QCNT_W-1:0]     count;

  assign full     = (count == bdtd_pkg::QCNT_W'(bdtd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

endmodule

/* hw/rtl/bdtd_back.sv */
// bdtd_back: per-channel state, calibration with constant divide, measurement
// and the result register; depends on bdtd_pkg
`timescale 1ns / 1ps

module bdtd_back #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned CAL_SAMPLES = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  bdtd_pkg::qentry_t            q_entry,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [bdtd_pkg::CH_W-1:0]    out_channel,
  output logic [bdtd_pkg::DEV_W-1:0]   deviation,
  output logic                         over_threshold,
  output logic [bdtd_pkg::MAX_CH-1:0]  frame_mask,
  output logic                         mask_valid
);

  localparam logic [bdtd_pkg::CH_W-1:0] LAST_CH = bdtd_pkg::CH_W'(CHANNELS - 1);
  localparam logic [bdtd_pkg::CNT_W-1:0] CAL_N  = bdtd_pkg::CNT_W'(CAL_SAMPLES);
  localparam logic [bdtd_pkg::MULT_W-1:0] DIV_MULT =
    bdtd_pkg::MULT_W'(((1 << bdtd_pkg::DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);

  // per-channel state
  logic signed [bdtd_pkg::VAL_W-1:0] baselines  [bdtd_pkg::MAX_CH];
  logic signed [bdtd_pkg::SUM_W-1:0] cal_sums   [bdtd_pkg::MAX_CH];
  logic [bdtd_pkg::CNT_W-1:0]        cal_counts [bdtd_pkg::MAX_CH];
  logic [bdtd_pkg::THR_W-1:0]        thresholds [bdtd_pkg::MAX_CH];
  logic [bdtd_pkg::MAX_CH-1:0]       running_mask;

  // divide pipeline
  logic                              s1_valid;
  logic [bdtd_pkg::ABS_W-1:0]        s1_abs;
  logic                              s1_neg;
  logic [bdtd_pkg::CH_W-1:0]         s1_ch;
  logic                              s2_valid;
  logic [bdtd_pkg::PROD_W-1:0]       s2_prod;
  logic                              s2_neg;
  logic [bdtd_pkg::CH_W-1:0]         s2_ch;
  logic                              busy;

  // result register
  logic                              out_valid;

  // request decode
  bdtd_pkg::qentry_t                 ent;
  logic [bdtd_pkg::CH_W-1:0]         ch;
  logic                              out_space;
  logic                              is_measure;
  logic                              is_cal;

  // calibration path
  logic signed [bdtd_pkg::SUM_W-1:0] sum_next;
  logic [bdtd_pkg::CNT_W-1:0]        cnt_next;
  logic                              cal_done;
  logic [bdtd_pkg::SUM_W-1:0]        sum_abs;
  logic [bdtd_pkg::VAL_W-1:0]        quot;
  logic signed [bdtd_pkg::VAL_W-1:0] base_new;

  // measure path
  logic signed [bdtd_pkg::DIFF_W-1:0] diff;
  logic [bdtd_pkg::DIFF_W-1:0]        diff_abs;
  logic [bdtd_pkg::VAL_W-1:0]         dev_full;
  logic                               over;
  logic [bdtd_pkg::DEV_W-1:0]         dev_sat;
  logic [bdtd_pkg::MAX_CH-1:0]        mask_upd;
  logic                               is_last;

  assign ent        = q_entry;
  assign ch         = q_entry.channel;
  assign busy       = s1_valid || s2_valid;
  assign out_space  = !out_valid || pop;
  assign is_measure = (ent.op == bdtd_pkg::OP_MEASURE);
  assign is_cal     = (ent.op == bdtd_pkg::OP_CAL);
  assign empty      = !out_valid;

  // hold the queue while a baseline is being worked out or the result waits
  assign q_pop = q_valid && !busy && (!is_measure || out_space);

  // calibration accumulate
  always_comb begin
    sum_next = cal_sums[ch] +
      $signed({{(bdtd_pkg::SUM_W - bdtd_pkg::VAL_W){ent.value[bdtd_pkg::VAL_W-1]}},
               ent.value});
    cnt_next = cal_counts[ch] + 1'b1;
    cal_done = (cnt_next >= CAL_N);
    sum_abs  = sum_next[bdtd_pkg::SUM_W-1] ? -sum_next : sum_next;
  end

  // quotient from the registered product, sign put back
  always_comb begin
    quot     = s2_prod[bdtd_pkg::DIV_SHIFT +: bdtd_pkg::VAL_W];
    base_new = s2_neg ? $signed(-quot) : $signed(quot);
  end

  // deviation and threshold test
  always_comb begin
    diff = $signed({ent.value[bdtd_pkg::VAL_W-1], ent.value}) -
           $signed({baselines[ch][bdtd_pkg::VAL_W-1], baselines[ch]});
    diff_abs = diff[bdtd_pkg::DIFF_W-1] ? -diff : diff;
    dev_full = diff_abs[bdtd_pkg::VAL_W-1:0];
    over     = (dev_full > {3'b000, thresholds[ch]});
    dev_sat  = (|dev_full[bdtd_pkg::VAL_W-1:bdtd_pkg::DEV_W]) ? bdtd_pkg::DEV_MAX
                                                               : dev_full[bdtd_pkg::DEV_W-1:0];
    mask_upd = running_mask | ({{(bdtd_pkg::MAX_CH-1){1'b0}}, over} << ch);
    is_last  = (ch == LAST_CH);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bdtd_pkg::MAX_CH; i++) begin
        baselines[i]  <= '0;
        cal_sums[i]   <= '0;
        cal_counts[i] <= '0;
        thresholds[i] <= '0;
      end
      running_mask <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        unique case (ent.op)
          bdtd_pkg::OP_SET_ALL: begin
            for (int i = 0; i < bdtd_pkg::MAX_CH; i++) begin
              thresholds[i] <= ent.thr;
            end
          end
          bdtd_pkg::OP_SET_ONE: begin
            thresholds[ch] <= ent.thr;
          end
          bdtd_pkg::OP_CAL: begin
            if (cal_done) begin
              cal_sums[ch]   <= '0;
              cal_counts[ch] <= '0;
            end else begin
              cal_sums[ch]   <= sum_next;
              cal_counts[ch] <= cnt_next;
            end
          end
          bdtd_pkg::OP_MEASURE: begin
            running_mask <= is_last ? '0 : mask_upd;
          end
        endcase
      end

      // divide pipeline control
      s1_valid <= q_pop && is_cal && cal_done;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        baselines[s2_ch] <= base_new;
      end

      // result register occupancy
      if (q_pop && is_measure) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divide pipeline payload
  always_ff @(posedge clk) begin
    s1_abs  <= sum_abs[bdtd_pkg::ABS_W-1:0];
    s1_neg  <= sum_next[bdtd_pkg::SUM_W-1];
    s1_ch   <= ch;
    s2_prod <= bdtd_pkg::PROD_W'(s1_abs) * bdtd_pkg::PROD_W'(DIV_MULT);
    s2_neg  <= s1_neg;
    s2_ch   <= s1_ch;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop && is_measure) begin
      out_channel    <= ch;
      deviation      <= dev_sat;
      over_threshold <= over;
      frame_mask     <= is_last ? mask_upd : '0;
      mask_valid     <= is_last;
    end
  end

endmodule
